@@ src/dfe_pkg.sv @@
package dfe_pkg;

  // field widths
  localparam int PULSE_W   = 15;
  localparam int QUO_W     = 11;
  localparam int NUM_W     = PULSE_W + QUO_W;
  localparam int FRAME_W   = 16;
  localparam int BIT_IDX_W = 4;
  localparam int DUTY_W    = 4;
  localparam int CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX = 1'b1;

  // register reset values
  localparam logic [PULSE_W-1:0] PULSE_MIN_RST = 15'd1000;
  localparam logic [PULSE_W-1:0] PULSE_MAX_RST = 15'd2000;

  // throttle scaling and frame coding
  localparam logic [QUO_W-1:0]     FULL_SCALE      = 11'd2000;
  localparam logic [QUO_W-1:0]     THROTTLE_OFFSET = 11'd47;
  localparam logic [DUTY_W-1:0]    DUTY_ONE        = 4'd14;
  localparam logic [DUTY_W-1:0]    DUTY_ZERO       = 4'd7;
  localparam logic [BIT_IDX_W-1:0] LAST_IDX        = 4'd15;

  // scaled numerator and divisor handed to the divider
  typedef struct packed {
    logic [NUM_W-1:0]   num;
    logic [PULSE_W-1:0] den;
    logic               zero;
  } dfe_div_req_t;

  // divider result handed to the serializer
  typedef struct packed {
    logic [QUO_W-1:0] quo;
    logic             zero;
  } dfe_quo_t;

endpackage

@@ src/dshot_frame_encoder.sv @@
// Encodes one motor pulse width per input word into a 16-bit DShot frame
// and streams it out as sixteen bit words, most significant bit first, each
// carrying the timer compare count (14 for a one, 7 for a zero), the bit
// position, the whole frame and the throttle sent. The pulse is clamped to
// [pulse_min_us, pulse_max_us] (registers 0 and 1, reset 1000 and 2000) and
// scaled to 0..2000 by truncating division, then offset by 47 when nonzero;
// an empty or inverted range sends throttle 0. Inputs enter a 14-stage
// pipeline (clamp, scale, eleven restoring divide steps, frame build) ahead of
// the output register. The output serializer sends one bit word per cycle
// while out_ready is high and takes a new frame only after the last bit of
// the previous frame is taken; the next frame waits ready in the pipeline
// and follows that last bit with no gap. Configuration writes are always
// accepted and must be made while no frame is in flight.
module dshot_frame_encoder
  import dfe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PULSE_W-1:0]   cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PULSE_W-1:0]   in_pulse_us,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DUTY_W-1:0]    out_bit_duty,
  output logic [BIT_IDX_W-1:0] out_bit_index,
  output logic [FRAME_W-1:0]   out_frame_word,
  output logic [QUO_W-1:0]     out_throttle_code,
  output logic                 out_last_bit
);

  logic [PULSE_W-1:0] pulse_min_r;
  logic [PULSE_W-1:0] pulse_max_r;
  logic               req_vld;
  logic               req_rdy;
  dfe_div_req_t       req;
  logic               quo_vld;
  logic               quo_rdy;
  dfe_quo_t           quo;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_min_r <= PULSE_MIN_RST;
      pulse_max_r <= PULSE_MAX_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PULSE_MIN: pulse_min_r <= cfg_wdata;
        CFG_PULSE_MAX: pulse_max_r <= cfg_wdata;
      endcase
    end
  end

  // clamp and scale
  dfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .pulse_min (pulse_min_r),
    .pulse_max (pulse_max_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pulse  (in_pulse_us),
    .out_valid (req_vld),
    .out_ready (req_rdy),
    .out_req   (req)
  );

  // pipelined divide by the range width
  dfe_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req_vld),
    .in_ready  (req_rdy),
    .in_req    (req),
    .out_valid (quo_vld),
    .out_ready (quo_rdy),
    .out_quo   (quo)
  );

  // frame build and bit serializer
  dfe_ser u_ser (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (quo_vld),
    .in_ready          (quo_rdy),
    .in_quo            (quo),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_bit_duty      (out_bit_duty),
    .out_bit_index     (out_bit_index),
    .out_frame_word    (out_frame_word),
    .out_throttle_code (out_throttle_code),
    .out_last_bit      (out_last_bit)
  );

endmodule

@@ src/dfe_front.sv @@
module dfe_front
  import dfe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [PULSE_W-1:0] pulse_min,
  input  logic [PULSE_W-1:0] pulse_max,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [PULSE_W-1:0] in_pulse,
  output logic               out_valid,
  input  logic               out_ready,
  output dfe_div_req_t       out_req
);

  logic               a_vld_r;
  logic [PULSE_W-1:0] a_diff_r;
  logic [PULSE_W-1:0] a_den_r;
  logic               a_zero_r;
  logic               b_vld_r;
  dfe_div_req_t       b_req_r;
  logic               a_rdy;
  logic               b_rdy;
  logic [PULSE_W-1:0] clamp;
  logic               empty_rng;

  assign b_rdy = !b_vld_r || out_ready;
  assign a_rdy = !a_vld_r || b_rdy;
  assign in_ready = a_rdy;

  // saturate the pulse to the configured range
  assign empty_rng = (pulse_max <= pulse_min);
  always_comb begin
    clamp = in_pulse;
    if (in_pulse < pulse_min) begin
      clamp = pulse_min;
    end else if (in_pulse > pulse_max) begin
      clamp = pulse_max;
    end
  end

  // stage a: offset from minimum and range width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (a_rdy) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && in_valid) begin
      a_diff_r <= clamp - pulse_min;
      a_den_r  <= pulse_max - pulse_min;
      a_zero_r <= empty_rng;
    end
  end

  // stage b: scale the offset by full throttle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (b_rdy) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_rdy && a_vld_r) begin
      b_req_r.num  <= NUM_W'(a_diff_r) * NUM_W'(FULL_SCALE);
      b_req_r.den  <= a_den_r;
      b_req_r.zero <= a_zero_r;
    end
  end

  assign out_valid = b_vld_r;
  assign out_req   = b_req_r;

  // scaled numerator stays below the range width times 2048, so the quotient fits its 11 bits
  a_num_bound: assert property (@(posedge clk) disable iff (!rst_n)
    b_vld_r && !b_req_r.zero |->
      b_req_r.num[NUM_W-1:QUO_W] < b_req_r.den)
    else $error("scaled numerator exceeds quotient range");

endmodule

@@ src/dfe_div.sv @@
module dfe_div
  import dfe_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  dfe_div_req_t in_req,
  output logic         out_valid,
  input  logic         out_ready,
  output dfe_quo_t     out_quo
);

  // one restoring step per stage: remainder on top, quotient bits shift in at the bottom
  logic               vld_r  [QUO_W];
  logic [NUM_W-1:0]   work_r [QUO_W];
  logic [PULSE_W-1:0] den_r  [QUO_W];
  logic               zero_r [QUO_W];
  logic               rdy    [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stg
    logic               src_vld;
    logic [NUM_W-1:0]   src_work;
    logic [PULSE_W-1:0] src_den;
    logic               src_zero;
    logic               nxt_rdy;
    logic [PULSE_W:0]   trial;
    logic               ge;
    logic [PULSE_W-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign src_vld  = in_valid;
      assign src_work = in_req.num;
      assign src_den  = in_req.den;
      assign src_zero = in_req.zero;
    end else begin : g_next
      assign src_vld  = vld_r[k-1];
      assign src_work = work_r[k-1];
      assign src_den  = den_r[k-1];
      assign src_zero = zero_r[k-1];
    end

    if (k == QUO_W - 1) begin : g_tail
      assign nxt_rdy = out_ready;
    end else begin : g_mid
      assign nxt_rdy = rdy[k+1];
    end

    assign rdy[k] = !vld_r[k] || nxt_rdy;

    // compare and subtract against the range width
    assign trial   = src_work[NUM_W-1:QUO_W-1];
    assign ge      = (trial >= {1'b0, src_den});
    assign rem_nxt = ge ? PULSE_W'(trial - {1'b0, src_den}) : trial[PULSE_W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_vld) begin
        work_r[k] <= {rem_nxt, src_work[QUO_W-2:0], ge};
        den_r[k]  <= src_den;
        zero_r[k] <= src_zero;
      end
    end
  end

  assign in_ready     = rdy[0];
  assign out_valid    = vld_r[QUO_W-1];
  assign out_quo.quo  = work_r[QUO_W-1][QUO_W-1:0];
  assign out_quo.zero = zero_r[QUO_W-1];

  // the final remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[QUO_W-1] && !zero_r[QUO_W-1] |->
      work_r[QUO_W-1][NUM_W-1:QUO_W] < den_r[QUO_W-1])
    else $error("divider remainder not below divisor");

  // quotient never goes past full scale
  a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[QUO_W-1] && !zero_r[QUO_W-1] |->
      work_r[QUO_W-1][QUO_W-1:0] <= FULL_SCALE)
    else $error("divider quotient above full scale");

endmodule

@@ src/dfe_ser.sv @@
module dfe_ser
  import dfe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dfe_quo_t             in_quo,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DUTY_W-1:0]    out_bit_duty,
  output logic [BIT_IDX_W-1:0] out_bit_index,
  output logic [FRAME_W-1:0]   out_frame_word,
  output logic [QUO_W-1:0]     out_throttle_code,
  output logic                 out_last_bit
);

  logic                 f_vld_r;
  logic [QUO_W-1:0]     f_thr_r;
  logic [FRAME_W-1:0]   f_frame_r;
  logic                 f_rdy;
  logic                 s_rdy;
  logic                 out_vld_r;
  logic [BIT_IDX_W-1:0] cnt_r;
  logic [FRAME_W-1:0]   sh_r;
  logic [FRAME_W-1:0]   frame_r;
  logic [QUO_W-1:0]     thr_r;
  logic [QUO_W-1:0]     thr;
  logic [QUO_W:0]       word;
  logic [3:0]           csum;
  logic                 last;

  // throttle with offset, forced off for an empty range
  always_comb begin
    thr = '0;
    if (!in_quo.zero && in_quo.quo != '0) begin
      thr = in_quo.quo + THROTTLE_OFFSET;
    end
  end

  // frame: throttle, telemetry bit clear, nibble checksum
  assign word = {thr, 1'b0};
  assign csum = word[3:0] ^ word[7:4] ^ word[11:8];

  assign last  = (cnt_r == LAST_IDX);
  assign s_rdy = !out_vld_r || (out_ready && last);
  assign f_rdy = !f_vld_r || s_rdy;
  assign in_ready = f_rdy;

  // frame build stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (f_rdy) begin
      f_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f_rdy && in_valid) begin
      f_thr_r   <= thr;
      f_frame_r <= {word, csum};
    end
  end

  // serializer: one bit word per cycle while out_ready is high, msb first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      cnt_r     <= '0;
    end else if (s_rdy) begin
      out_vld_r <= f_vld_r;
      cnt_r     <= '0;
    end else if (out_ready) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_rdy && f_vld_r) begin
      sh_r    <= f_frame_r;
      frame_r <= f_frame_r;
      thr_r   <= f_thr_r;
    end else if (!s_rdy && out_ready) begin
      sh_r <= {sh_r[FRAME_W-2:0], 1'b0};
    end
  end

  assign out_valid         = out_vld_r;
  assign out_bit_duty      = sh_r[FRAME_W-1] ? DUTY_ONE : DUTY_ZERO;
  assign out_bit_index     = cnt_r;
  assign out_frame_word    = frame_r;
  assign out_throttle_code = thr_r;
  assign out_last_bit      = last;

  // a taken bit word that is not the last is followed by the next bit
  a_bit_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_ready && !last |=>
      out_vld_r && cnt_r == BIT_IDX_W'($past(cnt_r) + 1'b1))
    else $error("bit index did not advance");

  // nibbles of a complete frame xor to zero
  a_csum: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |->
      (frame_r[15:12] ^ frame_r[11:8] ^ frame_r[7:4] ^ frame_r[3:0]) == 4'h0)
    else $error("frame checksum mismatch");

  // frame carries the throttle and a clear telemetry bit
  a_frame_thr: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> frame_r[15:5] == thr_r && !frame_r[4])
    else $error("frame does not match throttle");

  // throttle is off or above the reserved command range
  a_thr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> thr_r == '0 || thr_r > THROTTLE_OFFSET)
    else $error("throttle in reserved range");

endmodule
